### hw/rtl/ppcu_pkg.sv
package ppcu_pkg;

  localparam int unsigned NumPlanes   = 6;
  localparam int unsigned PixPerGroup = 8;
  localparam int unsigned WordW       = 8;
  localparam int unsigned CntW        = $clog2(PixPerGroup);
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CfgDataW    = NumPlanes * WordW;

  // Channel bit pairs and output levels
  localparam logic [WordW-1:0] RedPair   = 8'h11;
  localparam logic [WordW-1:0] GreenPair = 8'h22;
  localparam logic [WordW-1:0] BluePair  = 8'h44;
  localparam logic [WordW-1:0] LowNibble = 8'h0f;
  localparam logic [WordW-1:0] LvlFull   = 8'd255;
  localparam logic [WordW-1:0] LvlHalf   = 8'd127;
  localparam logic [WordW-1:0] LvlOff    = 8'd0;

  // Register reset values
  localparam logic [CfgDataW-1:0]  ColorWordsRst = '0;
  localparam logic [WordW-1:0]     ColorMaskRst  = 8'hff;
  localparam logic [WordW-1:0]     BgColorRst    = 8'h00;
  localparam logic [NumPlanes-1:0] PlaneMaskRst  = 6'h3f;

  typedef enum logic [CfgIdxW-1:0] {
    CfgColorWords = 8'd0,
    CfgColorMask  = 8'd1,
    CfgBgColor    = 8'd2,
    CfgPlaneMask  = 8'd3
  } cfg_idx_e;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [PixPerGroup-1:0] group_t;

  typedef struct packed {
    word_t [NumPlanes-1:0] color_words;
    word_t                 color_mask;
    word_t                 bg_color;
    logic [NumPlanes-1:0]  plane_mask;
  } cfg_t;

  // Handshake between group buffer and serializer
  typedef struct packed {
    logic   valid;
    group_t words;
  } grp_req_t;

  function automatic word_t level_of(word_t w, word_t pair);
    word_t got;
    got = w & pair;
    if (got == pair) begin
      return LvlFull;
    end else if (got == (pair & LowNibble)) begin
      return LvlHalf;
    end
    return LvlOff;
  endfunction

endpackage

### hw/rtl/ppcu_lane.sv
// One pixel: plane bits -> color word
module ppcu_lane
  import ppcu_pkg::*;
(
  input  logic [NumPlanes-1:0] code_i,
  input  cfg_t                 cfg_i,
  output word_t                word_o
);

  word_t sel;
  word_t rest;

  always_comb begin
    sel  = '0;
    rest = '0;
    for (int unsigned j = 0; j < NumPlanes; j++) begin
      if (code_i[j]) begin
        if (cfg_i.color_mask[j]) begin
          sel = sel | cfg_i.color_words[j];
        end else begin
          rest = rest | cfg_i.color_words[j];
        end
      end
    end
    if (code_i == '0) begin
      word_o = cfg_i.bg_color;
    end else if (sel != '0) begin
      word_o = sel;
    end else begin
      word_o = rest;
    end
  end

endmodule

### hw/rtl/ppcu_merge.sv
// Serializes the lane results, one pixel per cycle while out_stall_i is low
module ppcu_merge
  import ppcu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  grp_req_t grp_i,
  output logic     take_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output word_t    red_level_o,
  output word_t    green_level_o,
  output word_t    blue_level_o,
  output logic     last_pixel_o
);

  group_t          ser_q, ser_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            vld_q, vld_d;
  logic            out_acc;
  logic            at_last;
  word_t           cur;

  assign at_last = (cnt_q == CntW'(PixPerGroup - 1));
  assign out_acc = vld_q && !out_stall_i;
  assign take_o  = grp_i.valid && (!vld_q || (out_acc && at_last));

  always_comb begin
    ser_d = ser_q;
    cnt_d = cnt_q;
    vld_d = vld_q;
    if (take_o) begin
      ser_d = grp_i.words;
      cnt_d = '0;
      vld_d = 1'b1;
    end else if (out_acc) begin
      if (at_last) begin
        vld_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ser_q <= ser_d;
  end

  assign cur           = ser_q[cnt_q];
  assign out_valid_o   = vld_q;
  assign red_level_o   = level_of(cur, RedPair);
  assign green_level_o = level_of(cur, GreenPair);
  assign blue_level_o  = level_of(cur, BluePair);
  assign last_pixel_o  = at_last;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && out_stall_i) |=> (vld_q && $stable(cnt_q)))
    else $error("pixel position moved under stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && at_last && !grp_i.valid) |=> !vld_q)
    else $error("serializer did not drain after last pixel");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !at_last) |=> (vld_q && cnt_q == $past(cnt_q) + 1'b1))
    else $error("pixel position did not advance");

endmodule

### hw/rtl/planar_pixel_color_unit_top.sv
// Planar pixel color unit.
// Input channel (in_valid_i / in_stall_o): one request carries one byte from
// each of six bit planes for an 8-pixel group; bit 0 is the first pixel.
// Output channel (out_valid_o / out_stall_i): one request per pixel with the
// red, green and blue levels (0, 127 or 255); last_pixel_o marks the eighth.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 plane color words,
// 1 color mask, 2 background color, 3 plane mask; other indexes are dropped.
// cfg_ready_o is always high; write only while no group is in flight.
// Eight lanes resolve all pixels of a group in the accept cycle and store the
// color words in a group buffer. The serializer then hands out one pixel per
// cycle while out_stall_i is low. The accepted group passes the group buffer
// and the serializer register before its first pixel is valid. The single
// output port limits the group rate; the next group waits in the buffer, so
// pixels stream with no gap between groups.
// Reset clears all valids and sets the registers to their reset values
// (color mask and plane mask all ones, others zero).
// A stall on the output freezes the current pixel; once the buffer is full,
// in_stall_o rises until the serializer takes the buffered group.
module planar_pixel_color_unit_top
  import ppcu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WordW-1:0]     plane0_byte_i,
  input  logic [WordW-1:0]     plane1_byte_i,
  input  logic [WordW-1:0]     plane2_byte_i,
  input  logic [WordW-1:0]     plane3_byte_i,
  input  logic [WordW-1:0]     plane4_byte_i,
  input  logic [WordW-1:0]     plane5_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WordW-1:0]     red_level_o,
  output logic [WordW-1:0]     green_level_o,
  output logic [WordW-1:0]     blue_level_o,
  output logic                 last_pixel_o
);

  // Config registers
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgColorWords: cfg_d.color_words = cfg_data_i;
        CfgColorMask:  cfg_d.color_mask  = cfg_data_i[WordW-1:0];
        CfgBgColor:    cfg_d.bg_color    = cfg_data_i[WordW-1:0];
        CfgPlaneMask:  cfg_d.plane_mask  = cfg_data_i[NumPlanes-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_words <= ColorWordsRst;
      cfg_q.color_mask  <= ColorMaskRst;
      cfg_q.bg_color    <= BgColorRst;
      cfg_q.plane_mask  <= PlaneMaskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Plane bytes, disabled planes forced to zero
  word_t [NumPlanes-1:0] planes;
  assign planes[0] = cfg_q.plane_mask[0] ? plane0_byte_i : '0;
  assign planes[1] = cfg_q.plane_mask[1] ? plane1_byte_i : '0;
  assign planes[2] = cfg_q.plane_mask[2] ? plane2_byte_i : '0;
  assign planes[3] = cfg_q.plane_mask[3] ? plane3_byte_i : '0;
  assign planes[4] = cfg_q.plane_mask[4] ? plane4_byte_i : '0;
  assign planes[5] = cfg_q.plane_mask[5] ? plane5_byte_i : '0;

  // Pixel lanes
  group_t lane_words;

  for (genvar k = 0; k < PixPerGroup; k++) begin : g_lane
    logic [NumPlanes-1:0] code;
    for (genvar j = 0; j < NumPlanes; j++) begin : g_bit
      assign code[j] = planes[j][k];
    end
    ppcu_lane u_lane (
      .code_i (code),
      .cfg_i  (cfg_q),
      .word_o (lane_words[k])
    );
  end

  // Group buffer between lanes and serializer
  group_t buf_q, buf_d;
  logic   buf_vld_q, buf_vld_d;
  logic   take;
  logic   in_acc;
  grp_req_t grp;

  assign in_stall_o = buf_vld_q && !take;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign buf_vld_d  = (buf_vld_q && !take) || in_acc;
  assign buf_d      = in_acc ? lane_words : buf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
    end else begin
      buf_vld_q <= buf_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign grp.valid = buf_vld_q;
  assign grp.words = buf_q;

  ppcu_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_i         (grp),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .last_pixel_o  (last_pixel_o)
  );

  a_acc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> buf_vld_q)
    else $error("accepted group not buffered");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (buf_vld_q && out_valid_o))
    else $error("input stalled with room available");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_vld_q && !out_valid_o) |-> take)
    else $error("idle serializer left buffered group");

endmodule
